// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SVPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/svpr_pkg.sv -----
`default_nettype none

package svpr_pkg;

   localparam int SERVO_SLOTS = 4;
   localparam int SLOT_W      = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;

   localparam int KIND_W     = 2;
   localparam int SEL_W      = 2;
   localparam int PIN_W      = 3;
   localparam int POS_W      = 12;
   localparam int OFFSET_W   = 10;
   localparam int PERIOD_W   = 16;
   localparam int FRAMES_W   = 8;
   localparam int LEVELS_W   = 8;
   localparam int SUM_W      = PERIOD_W + 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [OFFSET_W-1:0] RESET_OFFSET = OFFSET_W'(248);
   localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(4980);
   localparam logic [PERIOD_W-1:0] MIN_PERIOD   = PERIOD_W'(2);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RAMP = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_OFFSET    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_PERIOD    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAMES_PER_STEP = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [SEL_W-1:0]        servo_slot;
      logic [PIN_W-1:0]        pin_number;
      logic signed [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [LEVELS_W-1:0]     pin_levels;
      logic                    busy_res;
      logic signed [POS_W-1:0] ramp_position;
      logic signed [POS_W-1:0] slot_position;
      logic                    rejected;
   } rsp_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_wr_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] pulse_offset;
      logic [PERIOD_W-1:0] frame_period;
      logic [FRAMES_W-1:0] frames_per_step;
   } cfg_type;

   function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] period);
      return (period < MIN_PERIOD) ? MIN_PERIOD : period;
   endfunction

   // pulse width clamped to 1 .. period-1; period is already at least 2
   function automatic logic [PERIOD_W-1:0] high_len(input logic [OFFSET_W-1:0] offset,
                                                    input logic [PERIOD_W-1:0] period,
                                                    input logic signed [POS_W-1:0] pos);
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] top;
      sum = $signed(SUM_W'(offset)) + SUM_W'(pos);
      top = $signed(SUM_W'(period)) - $signed(SUM_W'(1));
      if (sum < $signed(SUM_W'(1))) sum = $signed(SUM_W'(1));
      if (sum > top) sum = top;
      return sum[PERIOD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/svpr_if.sv -----
`default_nettype none

interface svpr_req_if;
   logic             valid;
   logic             ready;
   svpr_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface svpr_rsp_if;
   logic             valid;
   logic             ready;
   svpr_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface svpr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [svpr_pkg::CSR_ADDR_W-1:0]    addr;
   logic [svpr_pkg::CSR_DATA_W-1:0]    wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/svpr_csr.sv -----
`default_nettype none

module svpr_csr (
   input  wire logic       clock,
   input  wire logic       reset,
   svpr_csr_if.sink        csr_ch,
   output svpr_pkg::cfg_type cfg
);
   import svpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_fire;

   assign csr_ch.ready = 1'b1;
   assign wr_fire      = csr_ch.valid & csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (csr_ch.addr)
            CSR_PULSE_OFFSET:    cfg_in.pulse_offset    = csr_ch.wdata[OFFSET_W-1:0];
            CSR_FRAME_PERIOD:    cfg_in.frame_period    = csr_ch.wdata[PERIOD_W-1:0];
            CSR_FRAMES_PER_STEP: cfg_in.frames_per_step = csr_ch.wdata[FRAMES_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_offset    <= RESET_OFFSET;
         cfg_ff.frame_period    <= RESET_PERIOD;
         cfg_ff.frames_per_step <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/svpr_engine.sv -----
`default_nettype none
`include "assert_macros.svh"

module svpr_engine (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_fire,
   input  wire svpr_pkg::req_type req_data,
   input  wire svpr_pkg::cfg_type cfg,
   output svpr_pkg::rsp_type  result
);
   import svpr_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0] cur;
      logic signed [POS_W-1:0] tgt;
      logic signed [POS_W-1:0] slot_mirror; // copy of the active slot's stored position
      logic [PIN_W-1:0]        pin;
      logic [SLOT_W-1:0]       aslot;
      logic [PERIOD_W-1:0]     ticks;
      logic [FRAMES_W-1:0]     frames;
      logic                    high;
      logic                    running;
      logic                    ramp;
   } eng_state_type;

   eng_state_type           state_ff;
   eng_state_type           state_in;
   eng_state_type           mid;
   logic signed [POS_W-1:0] slot_pos_ff [SERVO_SLOTS];
   logic                    slot_we;
   logic [SLOT_W-1:0]       slot_waddr;
   logic signed [POS_W-1:0] slot_wdata;
   logic [SLOT_W-1:0]       slot_idx;
   logic signed [POS_W-1:0] stored;
   logic [PERIOD_W-1:0]     period_eff;
   logic [PERIOD_W-1:0]     ticks;
   logic [FRAMES_W-1:0]     frames;
   logic signed [POS_W-1:0] step_pos;
   logic                    is_cmd;
   logic                    cmd_reject;

   assign period_eff = eff_period(cfg.frame_period);
   assign slot_idx   = SLOT_W'(req_data.servo_slot % SERVO_SLOTS);
   assign stored     = slot_pos_ff[slot_idx];
   assign is_cmd     = req_fire && (req_data.kind == KIND_SET || req_data.kind == KIND_RAMP);

   // command stage
   always_comb begin
      mid        = state_ff;
      cmd_reject = 1'b0;
      if (is_cmd) begin
         if (state_ff.running) begin
            cmd_reject = 1'b1;
         end else if (req_data.kind == KIND_SET) begin
            mid.pin = req_data.pin_number;
            if (cfg.frames_per_step != '0) begin
               mid.cur     = req_data.position;
               mid.frames  = cfg.frames_per_step;
               mid.ramp    = 1'b0;
               mid.running = 1'b1;
               mid.high    = 1'b1;
               mid.ticks   = high_len(cfg.pulse_offset, period_eff, req_data.position);
            end
         end else begin
            mid.pin         = req_data.pin_number;
            mid.aslot       = slot_idx;
            mid.slot_mirror = stored;
            if (req_data.position != stored) begin
               if (cfg.frames_per_step == '0) begin
                  mid.slot_mirror = req_data.position;
               end else begin
                  mid.tgt     = req_data.position;
                  mid.cur     = (req_data.position > stored) ? stored + POS_W'(1)
                                                             : stored - POS_W'(1);
                  mid.frames  = cfg.frames_per_step;
                  mid.ramp    = 1'b1;
                  mid.running = 1'b1;
                  mid.high    = 1'b1;
                  mid.ticks   = high_len(cfg.pulse_offset, period_eff, mid.cur);
               end
            end
         end
      end
   end

   // tick stage
   always_comb begin
      state_in          = mid;
      slot_we           = 1'b0;
      slot_waddr        = slot_idx;
      slot_wdata        = req_data.position;
      ticks             = mid.ticks;
      frames            = mid.frames;
      step_pos          = mid.cur;
      result.pin_levels = '0;
      if (is_cmd && !state_ff.running && req_data.kind == KIND_RAMP
          && req_data.position != stored && cfg.frames_per_step == '0) begin
         slot_we = 1'b1;
      end
      if (req_fire && mid.running) begin
         if (mid.high) result.pin_levels = LEVELS_W'(1) << mid.pin;
         if (ticks != '0) ticks = ticks - PERIOD_W'(1);
         state_in.ticks = ticks;
         if (ticks == '0) begin
            if (mid.high) begin
               state_in.high  = 1'b0;
               state_in.ticks = period_eff - high_len(cfg.pulse_offset, period_eff, mid.cur);
            end else begin
               if (frames != '0) frames = frames - FRAMES_W'(1);
               state_in.frames = frames;
               if (frames != '0) begin
                  state_in.high  = 1'b1;
                  state_in.ticks = high_len(cfg.pulse_offset, period_eff, mid.cur);
               end else if (mid.ramp && mid.cur != mid.tgt) begin
                  step_pos        = (mid.tgt > mid.cur) ? mid.cur + POS_W'(1)
                                                        : mid.cur - POS_W'(1);
                  state_in.cur    = step_pos;
                  state_in.frames = cfg.frames_per_step;
                  state_in.high   = 1'b1;
                  state_in.ticks  = high_len(cfg.pulse_offset, period_eff, step_pos);
               end else begin
                  if (mid.ramp) begin
                     slot_we              = 1'b1;
                     slot_waddr           = mid.aslot;
                     slot_wdata           = mid.tgt;
                     state_in.slot_mirror = mid.tgt;
                  end
                  state_in.running = 1'b0;
                  state_in.ramp    = 1'b0;
               end
            end
         end
      end
      result.busy_res      = req_fire && mid.running;
      result.ramp_position = state_in.cur;
      result.slot_position = state_in.slot_mirror;
      result.rejected      = cmd_reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SERVO_SLOTS; i++) slot_pos_ff[i] <= '0;
      end else if (slot_we) begin
         slot_pos_ff[slot_waddr] <= slot_wdata;
      end
   end

   `SVPR_ASSERT_NOW(a_run_has_ticks, clock, reset, state_ff.running, state_ff.ticks != '0)
   `SVPR_ASSERT_NOW(a_ramp_runs, clock, reset, state_ff.ramp, state_ff.running)
   `SVPR_ASSERT_NOW(a_reject_busy, clock, reset, result.rejected, result.busy_res)
   `SVPR_ASSERT_NOW(a_pulse_busy, clock, reset, result.pin_levels != '0, result.busy_res && $onehot(result.pin_levels))

endmodule

`default_nettype wire

// ----- rtl/core/svpr_out_buf.sv -----
`default_nettype none
`include "assert_macros.svh"

module svpr_out_buf (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire svpr_pkg::rsp_type push_data,
   output logic               push_ready,
   svpr_rsp_if.source         rsp_ch
);
   import svpr_pkg::*;

   rsp_type main_ff;
   rsp_type main_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    main_valid_ff;
   logic    main_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   logic    pop;

   assign pop        = main_valid_ff & rsp_ch.ready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         // head is stalled: park the request's result
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid = main_valid_ff;
   assign rsp_ch.data  = main_ff;

   `SVPR_ASSERT_NOW(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `SVPR_ASSERT_NEXT(a_stall_keeps_head, clock, reset, main_valid_ff && !rsp_ch.ready, main_valid_ff && main_ff == $past(main_ff))

endmodule

`default_nettype wire

// ----- rtl/core/servo_pulse_ramp_generator.sv -----
// Servo pulse generator, one request per tick.
// req_ch: requests (tick, direct set, ramp reposition); a request is taken
//   when valid and ready are high at a clock edge. Every request, tick or
//   command, produces exactly one response on rsp_ch, in order.
// rsp_ch: pin byte for the tick, busy flag, current ramp position, stored
//   position of the active slot, and a reject flag for commands that came
//   in while frames were still running.
// csr_ch: register writes, always ready; index 0 pulse offset, 1 frame
//   period, 2 frames per step. Write only while no request is in flight.
// Response: a request's result enters the output buffer when it is taken.
// Throughput: one request per cycle while the output buffer has room; the
//   tick logic is a single registered pass over the engine state.
// Stall: a two-entry output buffer keeps req_ch.ready high for one more
//   request after rsp_ch stalls, then drops it until the head is taken.
// Reset: synchronous; registers return to offset 248, period 4980,
//   zero frames per step; all slot positions and the pulse state clear,
//   and ready is high on the first cycle after reset.
`default_nettype none

module servo_pulse_ramp_generator (
   input  wire logic   clock,
   input  wire logic   reset,
   svpr_req_if.sink    req_ch,
   svpr_rsp_if.source  rsp_ch,
   svpr_csr_if.sink    csr_ch
);
   import svpr_pkg::*;

   cfg_type cfg;
   rsp_type result;
   logic    req_fire;
   logic    buf_ready;

   assign req_ch.ready = buf_ready;
   assign req_fire     = req_ch.valid & buf_ready;

   svpr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   svpr_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_ch.data),
      .cfg      (cfg),
      .result   (result)
   );

   svpr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (result),
      .push_ready (buf_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- bench/servo_pulse_ramp_generator_tb.sv -----
module servo_pulse_ramp_generator_tb;
   import svpr_pkg::*;

   localparam int IDLE_PCT  = 22;
   localparam int RUN_LIMIT = 150000;
   localparam int RANDOM_REQUESTS = 400;

   localparam logic [KIND_W-1:0]     KIND_SPARE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE  = 2'd3;

   typedef struct packed {
      logic [OFFSET_W-1:0]                  offset;
      logic [PERIOD_W-1:0]                  period;
      logic [FRAMES_W-1:0]                  fps;
      logic [SERVO_SLOTS-1:0][POS_W-1:0]    slot_pos;
      logic signed [POS_W-1:0]              step_pos;
      logic signed [POS_W-1:0]              target;
      logic [PIN_W-1:0]                     pin;
      logic [SLOT_W-1:0]                    slot;
      logic [PERIOD_W-1:0]                  ticks_left;
      logic [FRAMES_W-1:0]                  frames_left;
      logic                                 high_phase;
      logic                                 running;
      logic                                 ramping;
   } servo_model_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;

   svpr_req_if req_if();
   svpr_rsp_if rsp_if();
   svpr_csr_if csr_if();

   servo_pulse_ramp_generator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   servo_model_type plan_model;
   servo_model_type check_model;
   req_type      queued_requests[$];
   rsp_type      due_outputs[$];

   int n_items;
   int n_accepted;
   int n_busy;
   int n_rejects;
   int n_writes;
   int n_errors;
   int cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic servo_model_type servo_at_reset();
      servo_model_type s;
      s        = '0;
      s.offset = RESET_OFFSET;
      s.period = RESET_PERIOD;
      return s;
   endfunction

   function automatic int frame_len(servo_model_type s);
      return (s.period < 2) ? 2 : int'(s.period);
   endfunction

   // high time, clamped to 1 .. period-1
   function automatic logic [PERIOD_W-1:0] pulse_len(servo_model_type s,
                                                     logic signed [POS_W-1:0] p);
      int h;
      int top;
      h   = int'(s.offset) + int'(p);
      top = frame_len(s) - 1;
      if (h < 1) h = 1;
      if (h > top) h = top;
      return PERIOD_W'(h);
   endfunction

   function automatic void begin_frame(inout servo_model_type s);
      s.high_phase = 1'b1;
      s.ticks_left = pulse_len(s, s.step_pos);
   endfunction

   function automatic void apply_reg(inout servo_model_type s,
                                     input logic [CSR_ADDR_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PULSE_OFFSET:    s.offset = value[OFFSET_W-1:0];
         CSR_FRAME_PERIOD:    s.period = value;
         CSR_FRAMES_PER_STEP: s.fps    = value[FRAMES_W-1:0];
         default: ;
      endcase
   endfunction

   // one request = one tick of the pulse engine
   function automatic void tick_servo(inout servo_model_type s, input req_type rq,
                                      output rsp_type rs);
      logic [SLOT_W-1:0]       sl;
      logic signed [POS_W-1:0] want;
      logic signed [POS_W-1:0] stored;
      logic                    rej;
      logic                    busy;
      logic [LEVELS_W-1:0]     lv;
      sl   = SLOT_W'(int'(rq.servo_slot) % SERVO_SLOTS);
      want = rq.position;
      rej  = 1'b0;
      if (rq.kind == KIND_SET || rq.kind == KIND_RAMP) begin
         if (s.running) begin
            rej = 1'b1;
         end else if (rq.kind == KIND_SET) begin
            s.pin = rq.pin_number;
            if (s.fps != 0) begin
               s.step_pos    = want;
               s.frames_left = s.fps;
               s.ramping     = 1'b0;
               s.running     = 1'b1;
               begin_frame(s);
            end
         end else begin
            s.pin  = rq.pin_number;
            s.slot = sl;
            stored = $signed(s.slot_pos[sl]);
            if (want != stored) begin
               if (s.fps == 0) begin
                  s.slot_pos[sl] = want;
               end else begin
                  s.target      = want;
                  s.step_pos    = (want > stored) ? stored + 12'sd1 : stored - 12'sd1;
                  s.frames_left = s.fps;
                  s.ramping     = 1'b1;
                  s.running     = 1'b1;
                  begin_frame(s);
               end
            end
         end
      end

      busy = s.running;
      lv   = '0;
      if (s.running) begin
         if (s.high_phase) lv = LEVELS_W'(1) << s.pin;
         if (s.ticks_left != 0) s.ticks_left = s.ticks_left - 1'b1;
         if (s.ticks_left == 0) begin
            if (s.high_phase) begin
               // low length taken from the registers as they are now
               s.high_phase = 1'b0;
               s.ticks_left = PERIOD_W'(frame_len(s) - int'(pulse_len(s, s.step_pos)));
            end else begin
               if (s.frames_left != 0) s.frames_left = s.frames_left - 1'b1;
               if (s.frames_left != 0) begin
                  begin_frame(s);
               end else if (s.ramping && s.step_pos != s.target) begin
                  s.step_pos    = (s.target > s.step_pos) ? s.step_pos + 12'sd1
                                                          : s.step_pos - 12'sd1;
                  s.frames_left = s.fps;
                  begin_frame(s);
               end else begin
                  if (s.ramping) s.slot_pos[s.slot] = s.target;
                  s.running = 1'b0;
                  s.ramping = 1'b0;
               end
            end
         end
      end

      rs.pin_levels    = lv;
      rs.busy_res      = busy;
      rs.ramp_position = s.step_pos;
      rs.slot_position = $signed(s.slot_pos[s.slot]);
      rs.rejected      = rej;
   endfunction

   task automatic push_req(logic [KIND_W-1:0] kind, int slot, int pin, int pos);
      req_type r;
      rsp_type ignored;
      r.kind       = kind;
      r.servo_slot = SEL_W'(slot);
      r.pin_number = PIN_W'(pin);
      r.position   = POS_W'(pos);
      tick_servo(plan_model, r, ignored);
      queued_requests.push_back(r);
      n_items++;
   endtask

   task automatic push_tick();
      push_req(($urandom_range(7) == 0) ? KIND_SPARE : KIND_TICK, $urandom_range(3),
               $urandom_range(7), int'($signed(POS_W'($urandom))));
   endtask

   // tick while frames run (at most cap); noisy adds commands that land while busy
   task automatic drain_frames(int cap, bit noisy);
      while (plan_model.running && cap > 0) begin
         if (noisy && $urandom_range(15) == 0)
            push_req($urandom_range(1) ? KIND_SET : KIND_RAMP, $urandom_range(3),
                     $urandom_range(7), int'($signed(POS_W'($urandom))));
         else
            push_tick();
         cap--;
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_if.valid || due_outputs.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= idx;
      csr_if.wdata <= value;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      apply_reg(plan_model, idx, value);
      apply_reg(check_model, idx, value);
      n_writes++;
   endtask

   task automatic check_field(string field, int got, int want);
      if (got != want) begin
         n_errors++;
         if (n_errors <= 100)
            $display("%0t mismatch on %s: expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            tick_servo(check_model, req_if.data, want);
            due_outputs.push_back(want);
            n_accepted++;
            if (want.busy_res) n_busy++;
            if (want.rejected) n_rejects++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_if.valid <= 1'b1;
               req_if.data  <= queued_requests.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (due_outputs.size() == 0) begin
               n_errors++;
               if (n_errors <= 100)
                  $display("%0t unexpected response: expected none actual %p", $time, got);
            end else begin
               want = due_outputs.pop_front();
               check_field("pin_levels", int'(got.pin_levels), int'(want.pin_levels));
               check_field("busy_res", int'(got.busy_res), int'(want.busy_res));
               check_field("ramp_position", int'(got.ramp_position), int'(want.ramp_position));
               check_field("slot_position", int'(got.slot_position), int'(want.slot_position));
               check_field("rejected", int'(got.rejected), int'(want.rejected));
            end
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d requests still waiting for a response",
                  cycles, due_outputs.size() + queued_requests.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int phase;
      int pick;
      int sl;
      int pin;
      int stored;
      int tgt;
      int gap;
      int mark;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.addr  = '0;
      csr_if.wdata = '0;
      plan_model   = servo_at_reset();
      check_model  = servo_at_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset registers: no frames, so commands only load pin/slot or store
      push_tick();
      push_req(KIND_SET, 0, 7, 2047);
      push_req(KIND_RAMP, 1, 3, 2047);
      push_req(KIND_RAMP, 2, 0, -2048);
      push_req(KIND_RAMP, 1, 5, 2047);   // same target, stored position unchanged
      push_req(KIND_SPARE, 3, 6, -1);
      wait_idle();

      write_reg(CSR_SPARE, 16'hA5C3);
      write_reg(CSR_PULSE_OFFSET, 16'd0);
      write_reg(CSR_FRAME_PERIOD, 16'd2);
      write_reg(CSR_FRAMES_PER_STEP, 16'd1);
      push_req(KIND_SET, 2, 7, -2048);   // width clamps up to one tick
      push_req(KIND_SET, 0, 4, 100);     // lands while busy
      drain_frames(8, 1'b0);
      push_req(KIND_SET, 1, 0, 2047);    // width clamps down to period-1
      drain_frames(8, 1'b0);
      push_req(KIND_RAMP, 0, 2, 2);
      push_req(KIND_RAMP, 3, 1, 9);
      drain_frames(16, 1'b0);
      push_req(KIND_RAMP, 1, 6, 2045);   // steps downward
      drain_frames(16, 1'b0);
      wait_idle();

      // registers change in the middle of a high phase
      write_reg(CSR_PULSE_OFFSET, 16'd3);
      write_reg(CSR_FRAME_PERIOD, 16'd12);
      push_req(KIND_SET, 5, 6, 2);
      push_tick();
      push_tick();
      wait_idle();
      write_reg(CSR_PULSE_OFFSET, 16'hFFFF);
      write_reg(CSR_FRAME_PERIOD, 16'd0);
      drain_frames(40, 1'b0);
      wait_idle();
      write_reg(CSR_FRAME_PERIOD, 16'hFFFF);
      write_reg(CSR_FRAMES_PER_STEP, 16'h0000);
      push_req(KIND_RAMP, 3, 7, -1);
      wait_idle();

      mark    = n_items;
      phase   = 0;
      while (phase < 4 || n_items - mark < RANDOM_REQUESTS) begin
         phase++;
         calm = (phase == 2 || phase == 3);
         if (phase == 4) begin
            // largest frame count at the shortest period
            write_reg(CSR_PULSE_OFFSET, 16'($urandom));
            write_reg(CSR_FRAME_PERIOD, 16'($urandom_range(0, 2)));
            write_reg(CSR_FRAMES_PER_STEP, {8'($urandom), 8'd255});
            push_req(KIND_SET, $urandom_range(3), $urandom_range(7),
                     int'($signed(POS_W'($urandom))));
            drain_frames(2000, 1'b1);
         end else begin
            write_reg(CSR_PULSE_OFFSET, {6'($urandom), ($urandom_range(3) == 0) ?
                                         10'($urandom) : 10'($urandom_range(0, 12))});
            write_reg(CSR_FRAME_PERIOD, ($urandom_range(7) == 0) ?
                                        16'($urandom_range(0, 1)) : 16'($urandom_range(2, 9)));
            write_reg(CSR_FRAMES_PER_STEP, {8'($urandom), ($urandom_range(4) == 0) ?
                                            8'd0 : 8'($urandom_range(1, 2))});
            repeat ($urandom_range(3, 6)) begin
               pick   = $urandom_range(99);
               sl     = $urandom_range(3);
               pin    = $urandom_range(7);
               stored = int'($signed(plan_model.slot_pos[sl]));
               if (pick < 45) begin
                  if (plan_model.fps == 0 && $urandom_range(1) == 1) begin
                     tgt = int'($signed(POS_W'($urandom)));
                  end else begin
                     gap = $urandom_range(1, 3);
                     tgt = $urandom_range(1) ? stored + gap : stored - gap;
                     if (tgt > 2047 || tgt < -2048) tgt = 2 * stored - tgt;
                  end
                  push_req(KIND_RAMP, sl, pin, tgt);
               end else if (pick < 75) begin
                  push_req(KIND_SET, sl, pin, int'($signed(POS_W'($urandom))));
               end else if (pick < 85) begin
                  push_req(KIND_RAMP, sl, pin, stored);
               end else begin
                  repeat ($urandom_range(1, 5)) push_tick();
               end
               drain_frames(2000, 1'b1);
               if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) push_tick();
            end
         end
         wait_idle();
      end
      calm = 1'b0;

      repeat (8) @(posedge clock);
      $display("%0d requests over %0d register writes and %0d phases", n_accepted, n_writes,
               phase);
      $display("%0d cycles emitted pulse frames, %0d commands refused while busy, %0d mismatches",
               n_busy, n_rejects, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
